/* design/kvt_pkg.sv */
package kvt_pkg;

  // table geometry
  localparam int unsigned DEPTH      = 16;
  localparam int unsigned KEY_BITS   = 16;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EXISTS   = 2'd3;

  // one command transfer
  typedef struct packed {
    logic [1:0]            action;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] data_in;
  } kvt_cmd_t;

  // one result transfer
  typedef struct packed {
    logic                  found;
    logic [1:0]            status;
    logic [VALUE_BITS-1:0] data_out;
    logic [CNT_W-1:0]      entry_count;
    logic                  is_full;
    logic                  is_empty;
  } kvt_rsp_t;

  // signals broadcast to every cell
  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] data;
    logic                  del_en;
  } kvt_bcast_t;

  // per-cell slot control
  typedef struct packed {
    logic occ;
    logic ins_en;
  } kvt_slot_t;

endpackage

/* design/kvt_cell.sv */
module kvt_cell
  import kvt_pkg::*;
(
  input  logic                  clk_i,
  input  kvt_bcast_t            bcast_i,
  input  kvt_slot_t             slot_i,
  input  logic                  seen_i,
  input  logic [VALUE_BITS-1:0] acc_i,
  input  logic [KEY_BITS-1:0]   nbr_key_i,
  input  logic [VALUE_BITS-1:0] nbr_val_i,
  output logic                  seen_o,
  output logic [VALUE_BITS-1:0] acc_o,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [VALUE_BITS-1:0] val_o
);

  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  match;

  // compare against the command key, only for occupied slots
  assign match  = slot_i.occ && (key_q == bcast_i.key);
  assign seen_o = seen_i | match;
  assign acc_o  = acc_i | (match ? val_q : '0);
  assign key_o  = key_q;
  assign val_o  = val_q;

  // append, or take the upper neighbor at and above a deleted slot
  always_comb begin
    key_d = key_q;
    val_d = val_q;
    if (slot_i.ins_en) begin
      key_d = bcast_i.key;
      val_d = bcast_i.data;
    end else if (bcast_i.del_en && seen_o) begin
      key_d = nbr_key_i;
      val_d = nbr_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

endmodule

/* design/key_value_table.sv */
// channel   direction  handshake            payload
// command   in         start / busy         cmd_i (kvt_cmd_t)
// result    out        done_o strobe        rsp_o (kvt_rsp_t)
//
// One command per cycle: busy stays low, every cell compares its key and
// shifts in the cycle of the transfer, set by the match and shift chain.
// The result shows on rsp_o with done_o for one cycle, the cycle after
// the command transfer. Reset empties the table at once, no clearing pass.
// The receiver cannot stall; results are never held back.
module key_value_table
  import kvt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  kvt_cmd_t cmd_i,
  output logic     done_o,
  output kvt_rsp_t rsp_o
);

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  done_q;
  kvt_rsp_t              rsp_q, rsp_d;
  logic                  accept;
  logic                  hit, full;
  logic                  ins_ok, del_ok;
  kvt_bcast_t            bcast;
  kvt_slot_t             slot   [DEPTH];
  logic                  seen   [DEPTH+1];
  logic [VALUE_BITS-1:0] acc    [DEPTH+1];
  logic [KEY_BITS-1:0]   cell_key [DEPTH];
  logic [VALUE_BITS-1:0] cell_val [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CNT_W'(DEPTH));
  assign hit    = seen[DEPTH];

  // decode the command
  assign ins_ok = accept && (cmd_i.action == ACT_INSERT) && !hit && !full;
  assign del_ok = accept && (cmd_i.action == ACT_DELETE) && hit;

  assign bcast.key    = cmd_i.key;
  assign bcast.data   = cmd_i.data_in;
  assign bcast.del_en = del_ok;

  assign seen[0] = 1'b0;
  assign acc[0]  = '0;

  // row of cells, match and shift chain from slot 0 upward
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign slot[i].occ    = (CNT_W'(i) < count_q);
    assign slot[i].ins_en = ins_ok && (CNT_W'(i) == count_q);

    if (i == DEPTH - 1) begin : g_top
      kvt_cell u_cell (
        .clk_i     (clk_i),
        .bcast_i   (bcast),
        .slot_i    (slot[i]),
        .seen_i    (seen[i]),
        .acc_i     (acc[i]),
        .nbr_key_i (cell_key[i]),
        .nbr_val_i (cell_val[i]),
        .seen_o    (seen[i+1]),
        .acc_o     (acc[i+1]),
        .key_o     (cell_key[i]),
        .val_o     (cell_val[i])
      );
    end else begin : g_mid
      kvt_cell u_cell (
        .clk_i     (clk_i),
        .bcast_i   (bcast),
        .slot_i    (slot[i]),
        .seen_i    (seen[i]),
        .acc_i     (acc[i]),
        .nbr_key_i (cell_key[i+1]),
        .nbr_val_i (cell_val[i+1]),
        .seen_o    (seen[i+1]),
        .acc_o     (acc[i+1]),
        .key_o     (cell_key[i]),
        .val_o     (cell_val[i])
      );
    end
  end

  // occupancy
  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (del_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // result word
  always_comb begin
    rsp_d          = rsp_q;
    rsp_d.found    = hit;
    rsp_d.status   = ST_DONE;
    rsp_d.data_out = '0;
    case (cmd_i.action)
      ACT_INSERT: begin
        if (hit) begin
          rsp_d.status = ST_EXISTS;
        end else if (full) begin
          rsp_d.status = ST_FULL;
        end
      end
      default: begin
        if (hit) begin
          rsp_d.data_out = acc[DEPTH];
        end else begin
          rsp_d.status = ST_NOTFOUND;
        end
      end
    endcase
    rsp_d.entry_count = count_d;
    rsp_d.is_full     = (count_d == CNT_W'(DEPTH));
    rsp_d.is_empty    = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* design/kvt_checker.sv */
module kvt_checker
  import kvt_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input kvt_cmd_t cmd_i,
  input logic     done_o,
  input kvt_rsp_t rsp_o
);

  // every command transfer gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("missing result after command transfer");

  // no result without a command transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without command transfer");

  // flags agree with the count
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((rsp_o.is_full == (rsp_o.entry_count == CNT_W'(DEPTH))) &&
                (rsp_o.is_empty == (rsp_o.entry_count == '0))))
    else $error("full or empty flag disagrees with count");

  // a full status only on a full table
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == ST_FULL)) |-> rsp_o.is_full)
    else $error("full status on a table that is not full");

  // back to back results move the count by at most one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o)) |->
      ((rsp_o.entry_count == $past(rsp_o.entry_count)) ||
       (rsp_o.entry_count == $past(rsp_o.entry_count) + CNT_W'(1)) ||
       (rsp_o.entry_count == $past(rsp_o.entry_count) - CNT_W'(1))))
    else $error("entry count jumped");

endmodule

bind key_value_table kvt_checker u_kvt_checker (.*);
